/* hw/rtl/mfc_pkg.sv */
`default_nettype none
package mfc_pkg;

   localparam int BANK_W = 6;

   localparam logic [1:0] MODE_NORMAL = 2'd0;
   localparam logic [1:0] MODE_BANK   = 2'd1;
   localparam logic [1:0] MODE_LOOPER = 2'd2;

   localparam logic [2:0] LS_NONE      = 3'd0;
   localparam logic [2:0] LS_STOPPED   = 3'd1;
   localparam logic [2:0] LS_RECORDING = 3'd2;
   localparam logic [2:0] LS_OVERDUB   = 3'd3;
   localparam logic [2:0] LS_PLAYING   = 3'd4;

   localparam logic [1:0] BTN_ONE   = 2'd1;
   localparam logic [1:0] BTN_TWO   = 2'd2;
   localparam logic [1:0] BTN_THREE = 2'd3;

   localparam logic KIND_CC = 1'b0;
   localparam logic KIND_PC = 1'b1;

   localparam logic [6:0] CC_SNAPSHOT  = 7'd69;
   localparam logic [6:0] CC_REC_DUB   = 7'd60;
   localparam logic [6:0] CC_PLAY_STOP = 7'd61;
   localparam logic [6:0] CC_UNDO      = 7'd63;
   localparam logic [6:0] VAL_ON       = 7'd64;
   localparam logic [6:0] VAL_OFF      = 7'd0;

   localparam logic [4:0] STOMP_CH_RESET = 5'd1;
   localparam logic [4:0] AMP_CH_RESET   = 5'd2;

   localparam logic REG_STOMP_CHANNEL = 1'b0;
   localparam logic REG_AMP_CHANNEL   = 1'b1;

   typedef struct packed {
      logic       message_kind;
      logic [6:0] controller;
      logic [6:0] data_value;
      logic [4:0] channel;
      logic       last;
   } msg_type;

endpackage
`default_nettype wire

/* hw/rtl/mfc_channels.sv */
`default_nettype none
interface mfc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] button;
   logic       long_press;
   logic       mode_button;

   modport source (output valid, output button, output long_press, output mode_button,
                   input ready);
   modport sink (input valid, input button, input long_press, input mode_button,
                 output ready);
endinterface

interface mfc_rsp_if;
   logic       valid;
   logic       ready;
   logic       message_kind;
   logic [6:0] controller;
   logic [6:0] data_value;
   logic [4:0] channel;
   logic       last;

   modport source (output valid, output message_kind, output controller,
                   output data_value, output channel, output last, input ready);
   modport sink (input valid, input message_kind, input controller,
                 input data_value, input channel, input last, output ready);
endinterface
`default_nettype wire

/* hw/rtl/midi_footswitch_mode_controller_top.sv */
// footswitch to midi message controller
// req_if (sink): one footswitch event per transaction: button, long_press,
//    mode_button. the event is taken into an input register and decoded
//    from that register against the mode, bank, patch and looper state.
// rsp_if (source): midi messages, zero to two per event, last marks the
//    final message of an event; events that cause nothing emit nothing.
// csr_*: apb-style register port, stomp_channel at 0x0, amp_channel at 0x4,
//    pready always high; write only while no event is in flight.
// flow: an event passes through the input register and then the output
//    queue before its first message is valid. a new event can be taken
//    every cycle while the four-entry output queue has room for two
//    messages; with the receiver always ready the sustained rate is set
//    by the single output port.
// reset (synchronous): normal mode, bank 0, patch 0, no loop, channels
//    1 and 2, queue empty.
// receiver stall: messages wait in the queue; once fewer than two entries
//    are free the input register holds its event and req_if.ready drops.
`default_nettype none
module midi_footswitch_mode_controller_top #(
   parameter int MAX_BANK_INDEX = 41
) (
   input  wire         clock,
   input  wire         reset,
   mfc_req_if.sink     req_if,
   mfc_rsp_if.source   rsp_if,
   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire  [2:0]  csr_paddr,
   input  wire  [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import mfc_pkg::*;

   localparam logic [BANK_W-1:0] BANK_MAX = BANK_W'(MAX_BANK_INDEX);

   logic [4:0]        stomp_ch_ff, stomp_ch_in;
   logic [4:0]        amp_ch_ff, amp_ch_in;
   logic [1:0]        mode_ff, mode_in;
   logic [BANK_W-1:0] bank_ff, bank_in;
   logic [1:0]        patch_ff, patch_in;
   logic [2:0]        loop_ff, loop_in;

   logic       stg_valid_ff, stg_valid_in;
   logic [1:0] btn_ff, btn_in;
   logic       long_ff, long_in;
   logic       modeb_ff, modeb_in;

   msg_type    queue_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;

   logic       process, accept, pop, csr_write;
   logic       send_norm, send_one;
   logic       one_kind;
   logic [6:0] one_cc, one_val;
   logic [4:0] one_ch;
   logic [1:0] n_push;
   logic [7:0] prog_sum;
   msg_type    m0, m1;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == REG_AMP_CHANNEL) ? {27'd0, amp_ch_ff}
                                                         : {27'd0, stomp_ch_ff};

   always_comb begin
      stomp_ch_in = stomp_ch_ff;
      amp_ch_in   = amp_ch_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            REG_STOMP_CHANNEL: stomp_ch_in = csr_pwdata[4:0];
            REG_AMP_CHANNEL:   amp_ch_in   = csr_pwdata[4:0];
            default:           stomp_ch_in = stomp_ch_ff;
         endcase
      end
   end

   assign process       = stg_valid_ff && (count_ff <= 3'd2);
   assign req_if.ready  = !stg_valid_ff || process;
   assign accept        = req_if.valid && req_if.ready;
   assign pop           = rsp_if.valid && rsp_if.ready;

   assign stg_valid_in = accept ? 1'b1 : (process ? 1'b0 : stg_valid_ff);
   assign btn_in       = accept ? req_if.button : btn_ff;
   assign long_in      = accept ? req_if.long_press : long_ff;
   assign modeb_in     = accept ? req_if.mode_button : modeb_ff;

   // event decode
   always_comb begin
      mode_in   = mode_ff;
      bank_in   = bank_ff;
      patch_in  = patch_ff;
      loop_in   = loop_ff;
      send_norm = 1'b0;
      send_one  = 1'b0;
      one_kind  = KIND_CC;
      one_cc    = VAL_OFF;
      one_val   = VAL_OFF;
      one_ch    = stomp_ch_ff;
      if (modeb_ff) begin
         if (long_ff) begin
            mode_in = MODE_LOOPER;
         end else if (mode_ff != MODE_NORMAL) begin
            mode_in   = MODE_NORMAL;
            send_norm = 1'b1;
         end else begin
            mode_in = MODE_BANK;
         end
      end else if (mode_ff == MODE_NORMAL) begin
         if (!long_ff && btn_ff != 2'd0) begin
            patch_in  = btn_ff - 2'd1;
            send_norm = 1'b1;
         end
      end else if (mode_ff == MODE_BANK) begin
         if (!long_ff) begin
            if (btn_ff == BTN_ONE) begin
               bank_in = (bank_ff > '0) ? bank_ff - 1'b1 : BANK_MAX;
            end else if (btn_ff == BTN_THREE) begin
               bank_in = (bank_ff < BANK_MAX) ? bank_ff + 1'b1 : '0;
            end
            send_one = 1'b1;
            one_kind = KIND_PC;
            one_cc   = 7'd0;
            one_val  = 7'(bank_in);
         end
      end else if (mode_ff == MODE_LOOPER) begin
         if (long_ff) begin
            if (btn_ff == BTN_TWO && loop_ff == LS_STOPPED) begin
               loop_in = LS_NONE;
            end else if (btn_ff == BTN_THREE && loop_ff == LS_PLAYING) begin
               send_one = 1'b1;
               one_cc   = CC_UNDO;
               one_val  = VAL_ON;
            end
         end else begin
            case (btn_ff)
               BTN_ONE: begin
                  if (loop_ff == LS_STOPPED || loop_ff == LS_RECORDING ||
                      loop_ff == LS_OVERDUB) begin
                     loop_in  = LS_PLAYING;
                     send_one = 1'b1;
                     one_cc   = CC_PLAY_STOP;
                     one_val  = VAL_ON;
                  end
               end
               BTN_TWO: begin
                  if (loop_ff == LS_RECORDING || loop_ff == LS_OVERDUB ||
                      loop_ff == LS_PLAYING) begin
                     loop_in  = LS_STOPPED;
                     send_one = 1'b1;
                     one_cc   = CC_PLAY_STOP;
                     one_val  = VAL_OFF;
                  end
               end
               BTN_THREE: begin
                  if (loop_ff == LS_NONE) begin
                     loop_in  = LS_RECORDING;
                     send_one = 1'b1;
                     one_cc   = CC_REC_DUB;
                     one_val  = VAL_ON;
                  end else if (loop_ff == LS_STOPPED || loop_ff == LS_PLAYING ||
                               loop_ff == LS_RECORDING) begin
                     loop_in  = LS_OVERDUB;
                     send_one = 1'b1;
                     one_cc   = CC_REC_DUB;
                     one_val  = VAL_OFF;
                  end else if (loop_ff == LS_OVERDUB) begin
                     loop_in  = LS_PLAYING;
                     send_one = 1'b1;
                     one_cc   = CC_PLAY_STOP;
                     one_val  = VAL_ON;
                  end
               end
               default: loop_in = loop_ff;
            endcase
         end
      end
   end

   // message assembly
   assign prog_sum = {2'd0, bank_ff} + {1'b0, bank_ff, 1'b0} + {6'd0, patch_in};

   always_comb begin
      m0     = '0;
      m1     = '0;
      n_push = 2'd0;
      if (send_norm) begin
         m0     = '{message_kind: KIND_CC, controller: CC_SNAPSHOT,
                    data_value: {5'd0, patch_in}, channel: stomp_ch_ff, last: 1'b0};
         m1     = '{message_kind: KIND_PC, controller: 7'd0,
                    data_value: prog_sum[6:0], channel: amp_ch_ff, last: 1'b1};
         n_push = 2'd2;
      end else if (send_one) begin
         m0     = '{message_kind: one_kind, controller: one_cc,
                    data_value: one_val, channel: one_ch, last: 1'b1};
         n_push = 2'd1;
      end
      if (!process) begin
         n_push = 2'd0;
      end
   end

   assign wr_ptr_in = wr_ptr_ff + n_push;
   assign rd_ptr_in = rd_ptr_ff + {1'b0, pop};
   assign count_in  = count_ff + {1'b0, n_push} - {2'd0, pop};

   assign rsp_if.valid        = (count_ff != 3'd0);
   assign rsp_if.message_kind = queue_ff[rd_ptr_ff].message_kind;
   assign rsp_if.controller   = queue_ff[rd_ptr_ff].controller;
   assign rsp_if.data_value   = queue_ff[rd_ptr_ff].data_value;
   assign rsp_if.channel      = queue_ff[rd_ptr_ff].channel;
   assign rsp_if.last         = queue_ff[rd_ptr_ff].last;

   always_ff @(posedge clock) begin
      if (reset) begin
         stomp_ch_ff  <= STOMP_CH_RESET;
         amp_ch_ff    <= AMP_CH_RESET;
         mode_ff      <= MODE_NORMAL;
         bank_ff      <= '0;
         patch_ff     <= 2'd0;
         loop_ff      <= LS_NONE;
         stg_valid_ff <= 1'b0;
         wr_ptr_ff    <= 2'd0;
         rd_ptr_ff    <= 2'd0;
         count_ff     <= 3'd0;
      end else begin
         stomp_ch_ff  <= stomp_ch_in;
         amp_ch_ff    <= amp_ch_in;
         stg_valid_ff <= stg_valid_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         count_ff     <= count_in;
         if (process) begin
            mode_ff  <= mode_in;
            bank_ff  <= bank_in;
            patch_ff <= patch_in;
            loop_ff  <= loop_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      btn_ff   <= btn_in;
      long_ff  <= long_in;
      modeb_ff <= modeb_in;
      if (n_push != 2'd0) begin
         queue_ff[wr_ptr_ff] <= m0;
      end
      if (n_push == 2'd2) begin
         queue_ff[wr_ptr_ff + 2'd1] <= m1;
      end
   end

endmodule
`default_nettype wire
